// ===== rtl/gh_pkg.sv =====
// Shared constants, types and the base32 character table of the geohash encoder.
`default_nettype none

package gh_pkg;

  // Field widths
  localparam int LAT_W    = 40;
  localparam int LON_W    = 41;
  localparam int CRD_W    = 42;
  localparam int CNT_W    = 4;
  localparam int CHAR_W   = 7;
  localparam int CODE_W   = 5;
  localparam int BIT_CW   = 3;

  // Characters per coordinate and bits per character
  localparam int MAX_CHARS     = 12;
  localparam int BITS_PER_CHAR = 5;

  // Coordinate bounds in degrees * 2^32
  localparam logic signed [CRD_W-1:0] LAT_BOUND = 42'sd386547056640;
  localparam logic signed [CRD_W-1:0] LON_BOUND = 42'sd773094113280;

  // Register index decoded from the APB address
  localparam logic REG_CHAR_COUNT = 1'b0;

  typedef logic signed [CRD_W-1:0] crd_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic step;
    logic emit_char;
    logic emit_err;
    logic last;
  } gh_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic oor;
  } gh_sts_t;

  // Map a 5-bit code to its ASCII geohash character
  function automatic logic [CHAR_W-1:0] gh_alpha(input logic [CODE_W-1:0] code);
    logic [CHAR_W-1:0] ch;
    case (code)
      5'd0:    ch = 7'h30;
      5'd1:    ch = 7'h31;
      5'd2:    ch = 7'h32;
      5'd3:    ch = 7'h33;
      5'd4:    ch = 7'h34;
      5'd5:    ch = 7'h35;
      5'd6:    ch = 7'h36;
      5'd7:    ch = 7'h37;
      5'd8:    ch = 7'h38;
      5'd9:    ch = 7'h39;
      5'd10:   ch = 7'h62;
      5'd11:   ch = 7'h63;
      5'd12:   ch = 7'h64;
      5'd13:   ch = 7'h65;
      5'd14:   ch = 7'h66;
      5'd15:   ch = 7'h67;
      5'd16:   ch = 7'h68;
      5'd17:   ch = 7'h6A;
      5'd18:   ch = 7'h6B;
      5'd19:   ch = 7'h6D;
      5'd20:   ch = 7'h6E;
      5'd21:   ch = 7'h70;
      5'd22:   ch = 7'h71;
      5'd23:   ch = 7'h72;
      5'd24:   ch = 7'h73;
      5'd25:   ch = 7'h74;
      5'd26:   ch = 7'h75;
      5'd27:   ch = 7'h76;
      5'd28:   ch = 7'h77;
      5'd29:   ch = 7'h78;
      5'd30:   ch = 7'h79;
      5'd31:   ch = 7'h7A;
      default: ch = '0;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gh_dp.sv =====
// Geohash datapath: bisection unit, code shifter and output register.
`default_nettype none

module gh_dp (
  input  wire                                  clk_i,
  input  wire gh_pkg::gh_cmd_t                 cmd_i,
  output gh_pkg::gh_sts_t                      sts_o,
  input  wire logic signed [gh_pkg::LAT_W-1:0] latitude_i,
  input  wire logic signed [gh_pkg::LON_W-1:0] longitude_i,
  output logic [gh_pkg::CHAR_W-1:0]            hash_char_o,
  output logic                                 last_char_o,
  output logic                                 out_of_range_o
);
  import gh_pkg::*;

  crd_t lat_x_q, lon_x_q;
  crd_t lat_lo_q, lat_hi_q, lon_lo_q, lon_hi_q;
  logic lon_turn_q;
  logic [CODE_W-1:0] code_q;
  logic oor_q;
  logic [CHAR_W-1:0] hash_q;
  logic last_q, err_q;

  crd_t lat_ext, lon_ext;
  logic oor_d;
  crd_t sel_lo, sel_hi, sel_x, mid;
  logic signed [CRD_W:0] sum;
  logic bit_d;

  // Extend the inputs and check them against the bounds
  assign lat_ext = {{(CRD_W-LAT_W){latitude_i[LAT_W-1]}}, latitude_i};
  assign lon_ext = {{(CRD_W-LON_W){longitude_i[LON_W-1]}}, longitude_i};
  assign oor_d   = (lat_ext < -LAT_BOUND) || (lat_ext > LAT_BOUND) ||
                   (lon_ext < -LON_BOUND) || (lon_ext > LON_BOUND);

  // Shared midpoint adder and compare; lo + hi is always even
  always_comb begin
    sel_lo = lon_turn_q ? lon_lo_q : lat_lo_q;
    sel_hi = lon_turn_q ? lon_hi_q : lat_hi_q;
    sel_x  = lon_turn_q ? lon_x_q  : lat_x_q;
    sum    = {sel_lo[CRD_W-1], sel_lo} + {sel_hi[CRD_W-1], sel_hi};
    mid    = sum[CRD_W:1];
    bit_d  = sel_x > mid;
  end

  // Load the coordinate, then narrow one interval per step
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      lat_x_q    <= lat_ext;
      lon_x_q    <= lon_ext;
      lat_lo_q   <= -LAT_BOUND;
      lat_hi_q   <= LAT_BOUND;
      lon_lo_q   <= -LON_BOUND;
      lon_hi_q   <= LON_BOUND;
      lon_turn_q <= 1'b1;
      oor_q      <= oor_d;
    end else if (cmd_i.step) begin
      lon_turn_q <= ~lon_turn_q;
      code_q     <= {code_q[CODE_W-2:0], bit_d};
      if (lon_turn_q) begin
        if (bit_d) lon_lo_q <= mid;
        else       lon_hi_q <= mid;
      end else begin
        if (bit_d) lat_lo_q <= mid;
        else       lat_hi_q <= mid;
      end
    end
  end

  // Fill the output register with a character or the error result
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_char) begin
      hash_q <= gh_alpha(code_q);
      last_q <= cmd_i.last;
      err_q  <= 1'b0;
    end else if (cmd_i.emit_err) begin
      hash_q <= '0;
      last_q <= 1'b1;
      err_q  <= 1'b1;
    end
  end

  assign sts_o.oor      = oor_q;
  assign hash_char_o    = hash_q;
  assign last_char_o    = last_q;
  assign out_of_range_o = err_q;

endmodule

`default_nettype wire

// ===== rtl/gh_ctrl.sv =====
// Geohash controller: sequencing of bisection steps and output handshake.
`default_nettype none

module gh_ctrl (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  input  wire [gh_pkg::CNT_W-1:0]     count_i,
  input  wire gh_pkg::gh_sts_t        sts_i,
  output gh_pkg::gh_cmd_t             cmd_o
);
  import gh_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_STEP  = 5'b00100,
    S_EMIT  = 5'b01000,
    S_ERR   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [BIT_CW-1:0] bit_cnt_q, bit_cnt_d;
  logic [CNT_W-1:0]  char_cnt_q, char_cnt_d;
  logic out_valid_q, out_valid_d;
  logic [CNT_W-1:0] num_chars, last_idx;
  logic ofree;

  // Clamp the character count to 1..MAX_CHARS
  always_comb begin
    if (count_i == '0) begin
      num_chars = CNT_W'(1);
    end else if (count_i > CNT_W'(MAX_CHARS)) begin
      num_chars = CNT_W'(MAX_CHARS);
    end else begin
      num_chars = count_i;
    end
    last_idx = num_chars - CNT_W'(1);
  end

  assign ofree = !out_valid_q || out_ready_i;

  // Next state and datapath commands
  always_comb begin
    state_d     = state_q;
    bit_cnt_d   = bit_cnt_q;
    char_cnt_d  = char_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        bit_cnt_d  = '0;
        char_cnt_d = '0;
        state_d    = sts_i.oor ? S_ERR : S_STEP;
      end
      S_STEP: begin
        cmd_o.step = 1'b1;
        if (bit_cnt_q == BIT_CW'(BITS_PER_CHAR - 1)) begin
          bit_cnt_d = '0;
          state_d   = S_EMIT;
        end else begin
          bit_cnt_d = bit_cnt_q + BIT_CW'(1);
        end
      end
      S_EMIT: begin
        cmd_o.last = (char_cnt_q == last_idx);
        if (ofree) begin
          cmd_o.emit_char = 1'b1;
          out_valid_d     = 1'b1;
          if (cmd_o.last) begin
            state_d = S_IDLE;
          end else begin
            char_cnt_d = char_cnt_q + CNT_W'(1);
            state_d    = S_STEP;
          end
        end
      end
      S_ERR: begin
        if (ofree) begin
          cmd_o.emit_err = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bit_cnt_q   <= '0;
      char_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_cnt_q   <= bit_cnt_d;
      char_cnt_q  <= char_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/geohash_encoder.sv =====
// Geohash encoder top level: APB register, controller and datapath.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------
//  in      | input     | in_valid_i/in_ready_o | latitude_i, longitude_i
//  out     | output    | out_valid_o/out_ready_i | hash_char_o, last_char_o, out_of_range_o
//  cfg     | input     | psel/penable/pready   | paddr, pwdata, prdata (char_count)
//
// An item passes an accept state and a range-check state, then for each character
// five bisection steps on the shared midpoint adder and one emit step follow.
// An out-of-range item goes from the range check to the error state instead.
// Reset clears the controller and sets char_count to 12; no clearing pass.
// A stalled output holds the emit step; the input is taken again once the last
// transfer of an item is in the output register.
`default_nettype none

module geohash_encoder (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic signed [gh_pkg::LAT_W-1:0] latitude_i,
  input  wire logic signed [gh_pkg::LON_W-1:0] longitude_i,
  output logic                                 out_valid_o,
  input  wire                                  out_ready_i,
  output logic [gh_pkg::CHAR_W-1:0]            hash_char_o,
  output logic                                 last_char_o,
  output logic                                 out_of_range_o,
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire [2:0]                            paddr,
  input  wire [31:0]                           pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import gh_pkg::*;

  logic [CNT_W-1:0] char_count_q, char_count_d;
  gh_cmd_t cmd;
  gh_sts_t sts;
  logic wr_en;

  // Write char_count on the access phase of an APB write
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_CHAR_COUNT);

  always_comb begin
    char_count_d = char_count_q;
    if (wr_en) begin
      char_count_d = pwdata[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_count_q <= CNT_W'(MAX_CHARS);
    end else begin
      char_count_q <= char_count_d;
    end
  end

  // Return the register value on reads
  assign prdata = (paddr[2] == REG_CHAR_COUNT) ? {{(32-CNT_W){1'b0}}, char_count_q} : '0;

  gh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .count_i     (char_count_q),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gh_dp u_dp (
    .clk_i          (clk_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .latitude_i     (latitude_i),
    .longitude_i    (longitude_i),
    .hash_char_o    (hash_char_o),
    .last_char_o    (last_char_o),
    .out_of_range_o (out_of_range_o)
  );

`ifndef SYNTHESIS
  // An error result is a single, final, zero character
  a_err_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |-> last_char_o && (hash_char_o == '0))
    else $error("error result not marked last or not zero");

  // A normal result always carries a printable character
  a_char_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_of_range_o |-> (hash_char_o != '0))
    else $error("character result carries zero code");

  // The block is busy in the cycle after taking an item
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again right after a transfer");
`endif

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the geohash encoder: directed table, random coordinates.
`timescale 1ns / 100ps

module testbench;

  import gh_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 100;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 21;

  // Register map: char_count at index 0, anything else is a spare slot
  localparam logic [2:0] CHAR_COUNT_ADDR = {REG_CHAR_COUNT, 2'b00};
  localparam logic [2:0] SPARE_ADDR      = {~REG_CHAR_COUNT, 2'b00};

  // Coordinate limits and field extremes in degrees * 2^32
  localparam longint LAT_LIM = LAT_BOUND;
  localparam longint LON_LIM = LON_BOUND;
  localparam longint LAT_TOP = (64'sd1 <<< (LAT_W - 1)) - 1;
  localparam longint LAT_BOT = -(64'sd1 <<< (LAT_W - 1));
  localparam longint LON_TOP = (64'sd1 <<< (LON_W - 1)) - 1;
  localparam longint LON_BOT = -(64'sd1 <<< (LON_W - 1));

  localparam logic [255:0] GH_ALPHABET = "0123456789bcdefghjkmnpqrstuvwxyz";

  typedef enum logic [1:0] {ROW_COORD, ROW_WRITE} row_kind_e;
  typedef enum logic [1:0] {GOLD_NONE, GOLD_HASH, GOLD_OOR} gold_e;

  typedef struct packed {
    row_kind_e               kind;
    logic [2:0]              addr;
    logic [31:0]             data;
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
    gold_e                   gold;
    logic [95:0]             hash;
  } stim_row_t;

  typedef struct packed {
    logic [CHAR_W-1:0] hash_char;
    logic              last_char;
    logic              out_of_range;
  } gh_out_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic signed [LAT_W-1:0] latitude_i = '0;
  logic signed [LON_W-1:0] longitude_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [CHAR_W-1:0]       hash_char_o;
  logic                    last_char_o;
  logic                    out_of_range_o;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [2:0]              paddr = '0;
  logic [31:0]             pwdata = '0;
  logic [31:0]             prdata;
  logic                    pready;

  gh_out_t   pending_chars[$];
  stim_row_t dir_rows[$];
  logic [CNT_W-1:0] cfg_char_count = 4'd12;
  bit        burst = 1'b0;
  int        mismatches = 0;
  int        coords_sent = 0;
  int        oor_sent = 0;
  int        chars_checked = 0;
  int        writes_done = 0;
  int        cycle_count = 0;

  geohash_encoder uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .latitude_i    (latitude_i),
    .longitude_i   (longitude_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .hash_char_o   (hash_char_o),
    .last_char_o   (last_char_o),
    .out_of_range_o(out_of_range_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Clamp the programmed count to the supported character range
  function automatic int eff_count();
    if (cfg_char_count == 0) return 1;
    if (cfg_char_count > MAX_CHARS) return MAX_CHARS;
    return int'(cfg_char_count);
  endfunction

  function automatic void push_char(input logic [CHAR_W-1:0] ch, input logic last,
                                    input logic oor);
    gh_out_t c;
    c.hash_char    = ch;
    c.last_char    = last;
    c.out_of_range = oor;
    pending_chars.push_back(c);
    if (oor) oor_sent++;
  endfunction

  // Bisect longitude and latitude alternately, five bits per character
  function automatic void predict_hash(input logic signed [LAT_W-1:0] lat,
                                       input logic signed [LON_W-1:0] lon);
    longint lat_v, lon_v, lat_lo, lat_hi, lon_lo, lon_hi, mid;
    logic [CODE_W-1:0] code;
    bit lon_turn;
    int n, k, j;
    lat_v = lat;
    lon_v = lon;
    if (lat_v < -LAT_LIM || lat_v > LAT_LIM || lon_v < -LON_LIM || lon_v > LON_LIM) begin
      push_char('0, 1'b1, 1'b1);
      return;
    end
    lat_lo = -LAT_LIM;
    lat_hi = LAT_LIM;
    lon_lo = -LON_LIM;
    lon_hi = LON_LIM;
    lon_turn = 1'b1;
    n = eff_count();
    for (k = 0; k < n; k++) begin
      code = '0;
      for (j = 0; j < BITS_PER_CHAR; j++) begin
        if (lon_turn) begin
          mid = lon_lo + (lon_hi - lon_lo) / 2;
          if (lon_v > mid) begin
            lon_lo = mid;
            code = {code[CODE_W-2:0], 1'b1};
          end else begin
            lon_hi = mid;
            code = {code[CODE_W-2:0], 1'b0};
          end
        end else begin
          mid = lat_lo + (lat_hi - lat_lo) / 2;
          if (lat_v > mid) begin
            lat_lo = mid;
            code = {code[CODE_W-2:0], 1'b1};
          end else begin
            lat_hi = mid;
            code = {code[CODE_W-2:0], 1'b0};
          end
        end
        lon_turn = !lon_turn;
      end
      push_char(GH_ALPHABET[8 * (31 - code) +: CHAR_W], k == n - 1, 1'b0);
    end
  endfunction

  // Draw one coordinate: mostly in range, some at the bounds, raw bits and near zero
  function automatic longint pick_coord(input longint lim, input int width);
    longint unsigned raw;
    longint v;
    int mode;
    raw  = {$urandom, $urandom};
    mode = $urandom_range(0, 99);
    if (mode < 70) begin
      v = longint'(raw % longint'(2 * lim + 1)) - lim;
    end else if (mode < 80) begin
      v = lim - 2 + longint'($urandom_range(0, 4));
      if ($urandom_range(0, 1) == 1) v = -v;
    end else if (mode < 90) begin
      v = longint'(raw << (64 - width)) >>> (64 - width);
    end else begin
      v = longint'($urandom_range(0, 4000)) - 2000;
    end
    return v;
  endfunction

  function automatic void add_coord(input longint lat, input longint lon, input gold_e gold,
                                    input logic [95:0] hash);
    stim_row_t r;
    r      = '0;
    r.kind = ROW_COORD;
    r.lat  = lat[LAT_W-1:0];
    r.lon  = lon[LON_W-1:0];
    r.gold = gold;
    r.hash = hash;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_write(input logic [2:0] addr, input logic [31:0] data);
    stim_row_t r;
    r      = '0;
    r.kind = ROW_WRITE;
    r.addr = addr;
    r.data = data;
    dir_rows.push_back(r);
  endfunction

  // One APB transfer: setup phase, then access until pready
  task automatic apb_access(input bit wr, input logic [2:0] addr, input logic [31:0] data,
                            output logic [31:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_char_count();
    logic [31:0] rd;
    apb_access(1'b0, CHAR_COUNT_ADDR, '0, rd);
    if (rd !== {28'd0, cfg_char_count}) begin
      $error("char_count readback: expected %0d, got %0d", cfg_char_count, rd);
      mismatches++;
    end
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    logic [31:0] unused;
    apb_access(1'b1, addr, data, unused);
    if (addr == CHAR_COUNT_ADDR) cfg_char_count = data[CNT_W-1:0];
    writes_done++;
    check_char_count();
  endtask

  // Drop valid and hold until every expected character has arrived
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
  endtask

  // Offer one coordinate pair; valid stays high after the transfer for the next caller
  task automatic offer_coord(input logic signed [LAT_W-1:0] lat,
                             input logic signed [LON_W-1:0] lon,
                             input gold_e gold, input logic [95:0] hash);
    int gap, n, k;
    gap = burst ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    latitude_i  <= lat;
    longitude_i <= lon;
    do @(posedge clk_i); while (!in_ready_o);
    coords_sent++;
    case (gold)
      GOLD_HASH: begin
        n = eff_count();
        for (k = 0; k < n; k++) push_char(hash[8 * (n - 1 - k) +: CHAR_W], k == n - 1, 1'b0);
      end
      GOLD_OOR: push_char('0, 1'b1, 1'b1);
      default:  predict_hash(lat, lon);
    endcase
  endtask

  // Receive side: stall at random, then check each transfer against the oldest expectation
  initial begin : result_sink
    int stall;
    gh_out_t want;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      chars_checked++;
      if (pending_chars.size() == 0) begin
        $error("unexpected result: hash_char %h last_char %b out_of_range %b",
               hash_char_o, last_char_o, out_of_range_o);
        mismatches++;
      end else begin
        want = pending_chars.pop_front();
        if (hash_char_o !== want.hash_char) begin
          $error("hash_char: expected %h, got %h", want.hash_char, hash_char_o);
          mismatches++;
        end
        if (last_char_o !== want.last_char) begin
          $error("last_char: expected %b, got %b", want.last_char, last_char_o);
          mismatches++;
        end
        if (out_of_range_o !== want.out_of_range) begin
          $error("out_of_range: expected %b, got %b", want.out_of_range, out_of_range_o);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t r;
    logic [31:0] wdata;
    logic [CNT_W-1:0] cnt;
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
    int ph, i;

    // Directed table, reset count of twelve first
    add_coord(0, 0, GOLD_HASH, "7zzzzzzzzzzz");
    add_coord(-LAT_LIM, -LON_LIM, GOLD_HASH, "000000000000");
    add_coord(LAT_LIM, LON_LIM, GOLD_HASH, "zzzzzzzzzzzz");
    add_coord(-LAT_LIM, LON_LIM, GOLD_NONE, '0);
    add_coord(LAT_LIM, -LON_LIM, GOLD_NONE, '0);
    add_coord(-1, -1, GOLD_NONE, '0);
    add_coord(1, 1, GOLD_NONE, '0);
    add_coord(LAT_LIM + 1, 0, GOLD_OOR, '0);
    add_coord(-LAT_LIM - 1, 0, GOLD_OOR, '0);
    add_coord(0, LON_LIM + 1, GOLD_OOR, '0);
    add_coord(0, -LON_LIM - 1, GOLD_OOR, '0);
    add_coord(LAT_TOP, LON_BOT, GOLD_OOR, '0);
    add_coord(LAT_BOT, LON_TOP, GOLD_OOR, '0);
    add_write(CHAR_COUNT_ADDR, 32'd1);
    add_coord(LAT_LIM, LON_LIM, GOLD_HASH, "z");
    add_coord(-LAT_LIM, -LON_LIM, GOLD_HASH, "0");
    add_coord(LAT_LIM + 1, LON_LIM + 1, GOLD_OOR, '0);
    // zero count acts as one
    add_write(CHAR_COUNT_ADDR, 32'd0);
    add_coord(0, 0, GOLD_HASH, "7");
    // counts above the maximum clamp to twelve
    add_write(CHAR_COUNT_ADDR, 32'hFFFF_FFFF);
    add_coord(0, 0, GOLD_HASH, "7zzzzzzzzzzz");
    add_write(CHAR_COUNT_ADDR, 32'hA5A5_A5AD);
    add_coord(LAT_LIM, LON_LIM, GOLD_HASH, "zzzzzzzzzzzz");
    // spare register slot must leave the count alone
    add_write(SPARE_ADDR, 32'd3);
    add_coord(LAT_LIM, LON_LIM, GOLD_HASH, "zzzzzzzzzzzz");
    add_write(CHAR_COUNT_ADDR, 32'd5);
    add_coord(0, 0, GOLD_HASH, "7zzzz");
    add_coord(-LAT_LIM, -LON_LIM, GOLD_HASH, "00000");

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    check_char_count();

    foreach (dir_rows[idx]) begin
      r = dir_rows[idx];
      if (r.kind == ROW_WRITE) begin
        wait_drained();
        cfg_write(r.addr, r.data);
      end else begin
        offer_coord(r.lat, r.lon, r.gold, r.hash);
      end
    end

    // Random phases, each under a fresh count; one phase runs without idling
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      wait_drained();
      burst = (ph == 2);
      if (ph == 0) cnt = 4'd1;
      else if (ph == 1) cnt = 4'd12;
      else cnt = CNT_W'($urandom_range(0, 15));
      wdata = $urandom;
      wdata[CNT_W-1:0] = cnt;
      cfg_write(CHAR_COUNT_ADDR, wdata);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 3 && i == PHASE_ITEMS / 2) wait_drained();
        lat = LAT_W'(pick_coord(LAT_LIM, LAT_W));
        lon = LON_W'(pick_coord(LON_LIM, LON_W));
        offer_coord(lat, lon, GOLD_NONE, '0);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d coordinates (%0d out of range) over %0d register writes",
             coords_sent, oor_sent, writes_done);
    $display("checked %0d character transfers, %0d failures", chars_checked, mismatches);
    if (mismatches == 0 && pending_chars.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
